/* rtl/eps_pkg.sv */
`timescale 1ns / 1ps

package eps_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  // holds CAPACITY, the largest position a scan can step to
  localparam int CNT_W    = $clog2(CAPACITY + 2);

  localparam logic [CNT_W-1:0] STRIDE  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_HEAD,
    ST_SWAP_PICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic ovf;
  } emit_t;

endpackage

/* rtl/even_position_selection_sort.sv */
`timescale 1ns / 1ps

// Channel | Dir | tdata            | tlast    | tuser
// s_axis  | in  | [31:0] value     | last     | -
// m_axis  | out | [31:0] value_res | last_res | overflow
//
// Loading writes each accepted word to the next free store location until the store is
// full. After the closing word the even positions are sorted by repeated minimum scans
// over one RAM read port. Read-out issues a new RAM read only after the previous word
// has come back from the registered RAM read.
// Reset clears control state only; the element store is not cleared.
// s_axis_tready is high only while loading; a stalled m_axis holds the read-out.
module even_position_selection_sort
  import eps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [VAL_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic             s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [VAL_W-1:0] m_axis_tdata,   // [31:0] value_res
  output logic             m_axis_tlast,   // last_res
  output logic             m_axis_tuser    // [0] overflow
);

  ram_req_t         ram_req;
  emit_t            emit;
  logic [VAL_W-1:0] rd_data;
  logic             out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  eps_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  eps_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_value (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .out_free (out_free),
    .rd_data  (rd_data),
    .ram_req  (ram_req),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.vld) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      m_axis_tdata <= rd_data;
      m_axis_tlast <= emit.last;
      m_axis_tuser <= emit.ovf;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    emit.vld |-> !m_axis_tvalid)
    else $error("output word overwritten before taken");

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !emit.vld)
    else $error("input accepted during read-out");

endmodule

/* rtl/eps_ram.sv */
`timescale 1ns / 1ps

module eps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/eps_seq.sv */
`timescale 1ns / 1ps

module eps_seq
  import eps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_value,
  input  logic             in_last,
  input  logic             out_free,
  input  logic [VAL_W-1:0] rd_data,
  output ram_req_t         ram_req,
  output emit_t            emit
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [CNT_W-1:0]  head;
  logic [CNT_W-1:0]  scan;
  logic [CNT_W-1:0]  ptr;
  logic              rd_pend;
  logic [ADDR_W-1:0] rd_idx;
  logic [VAL_W-1:0]  min_val;
  logic [ADDR_W-1:0] min_idx;
  logic [VAL_W-1:0]  head_val;

  logic [CNT_W-1:0]  head_adv;
  logic              in_acc;
  logic              issue_scan;
  logic              issue_emit;

  assign head_adv = head + STRIDE;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && in_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan >= count && !rd_pend) state_next = ST_SWAP_HEAD;
      end
      ST_SWAP_HEAD: begin
        state_next = ST_SWAP_PICK;
      end
      ST_SWAP_PICK: begin
        if (head_adv >= count) state_next = ST_EMIT;
        else state_next = ST_SCAN;
      end
      ST_EMIT: begin
        if (ptr >= count && !rd_pend) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    issue_scan    = 1'b0;
    issue_emit    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = count[ADDR_W-1:0];
    ram_req.wdata = in_value;
    ram_req.raddr = scan[ADDR_W-1:0];
    unique case (state)
      ST_LOAD: begin
        in_ready   = 1'b1;
        ram_req.we = in_valid && (count < CAP_CNT);
      end
      ST_SCAN: begin
        issue_scan = scan < count;
      end
      ST_SWAP_HEAD: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = head[ADDR_W-1:0];
        ram_req.wdata = min_val;
      end
      ST_SWAP_PICK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = min_idx;
        ram_req.wdata = head_val;
      end
      ST_EMIT: begin
        issue_emit    = (ptr < count) && !rd_pend && out_free;
        ram_req.raddr = ptr[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
    emit.vld  = (state == ST_EMIT) && rd_pend;
    emit.last = (CNT_W'(rd_idx) + CNT_W'(1)) == count;
    emit.ovf  = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      head    <= '0;
      scan    <= '0;
      ptr     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue_scan || issue_emit;
      if (in_acc) begin
        if (count < CAP_CNT) count <= count + CNT_W'(1);
        else ovf <= 1'b1;
        if (in_last) begin
          head <= '0;
          scan <= '0;
        end
      end
      if (issue_scan) scan <= scan + STRIDE;
      if (state == ST_SWAP_PICK) begin
        head <= head_adv;
        scan <= head_adv;
        ptr  <= '0;
      end
      if (issue_emit) ptr <= ptr + CNT_W'(1);
      // batch fully read out: start a new one
      if (state == ST_EMIT && state_next == ST_LOAD) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ram_req.raddr;
    if (state == ST_SCAN && rd_pend) begin
      // first word of a scan is the head itself; keep the first minimum found
      if (rd_idx == head[ADDR_W-1:0]) begin
        min_val  <= rd_data;
        min_idx  <= rd_idx;
        head_val <= rd_data;
      end else if ($signed(rd_data) < $signed(min_val)) begin
        min_val <= rd_data;
        min_idx <= rd_idx;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state != ST_EMIT))
    else $error("store written during read-out");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_pend) |-> (CNT_W'(rd_idx) < count))
    else $error("scan read beyond stored elements");

endmodule
